/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file, clocked on aclk with aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define AFB_ASSERT_HOLDS(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("afb assertion failed");

// consequent that must hold in the cycle after the antecedent
`define AFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("afb assertion failed");

`endif

/* hw/rtl/afb_pkg.sv */
// types and constants of the api transmit frame builder
`timescale 1ns / 1ps

package afb_pkg;

    localparam logic       ACT_START    = 1'b0;
    localparam logic       ACT_DATA     = 1'b1;

    localparam logic [7:0]  START_BYTE   = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE   = 8'h01;
    localparam logic [7:0]  FRAME_ID     = 8'h01;
    localparam logic [7:0]  OPTION_BYTE  = 8'h00;
    localparam logic [7:0]  CHECK_BASE   = 8'hFF;
    localparam logic [15:0] LEN_OVERHEAD = 16'd7;

    // byte positions within the header sequence of a start item
    localparam int          IDX_W        = 4;
    localparam logic [IDX_W-1:0] IDX_START    = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LEN_HI   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LEN_LO   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_TYPE     = 4'd3;
    localparam logic [IDX_W-1:0] IDX_ID       = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ADDR_HI  = 4'd5;
    localparam logic [IDX_W-1:0] IDX_ADDR_LO  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_OPTION   = 4'd7;
    localparam logic [IDX_W-1:0] IDX_INSTR    = 4'd8;
    localparam logic [IDX_W-1:0] IDX_SLAVE    = 4'd9;
    localparam logic [IDX_W-1:0] IDX_CHECK    = 4'd10;
    // position of the checksum after a closing payload byte
    localparam logic [IDX_W-1:0] IDX_DATA_CHK = 4'd1;

    typedef struct packed {
        logic        action;
        logic [7:0]  payload_length;
        logic [15:0] dest_address;
        logic [7:0]  instruction;
        logic [7:0]  slave_address;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error;
    } out_item_t;

    typedef struct packed {
        logic       in_frame;
        logic [7:0] bytes_remaining;
        logic [7:0] running_sum;
    } frame_state_t;

    typedef struct packed {
        out_item_t    res;
        logic         last;
        frame_state_t state_next;
    } step_t;

endpackage

/* hw/rtl/afb_byte_sel.sv */
// selects one frame byte for the held item and computes the next frame state
`timescale 1ns / 1ps

module afb_byte_sel (
    input  afb_pkg::in_item_t            item,
    input  logic [afb_pkg::IDX_W-1:0]    idx,
    input  afb_pkg::frame_state_t        state,
    output afb_pkg::step_t               step
);

    logic [15:0] len;
    logic [7:0]  rem_dec;
    logic [7:0]  check;

    assign len     = {8'd0, item.payload_length} + afb_pkg::LEN_OVERHEAD;
    assign rem_dec = state.bytes_remaining - 8'd1;
    assign check   = afb_pkg::CHECK_BASE - state.running_sum;

    always_comb begin
        step            = '0;
        step.state_next = state;
        if (item.action == afb_pkg::ACT_START) begin
            case (idx)
                afb_pkg::IDX_START:   step.res.out_byte = afb_pkg::START_BYTE;
                afb_pkg::IDX_LEN_HI:  step.res.out_byte = len[15:8];
                afb_pkg::IDX_LEN_LO:  step.res.out_byte = len[7:0];
                afb_pkg::IDX_TYPE:    step.res.out_byte = afb_pkg::FRAME_TYPE;
                afb_pkg::IDX_ID:      step.res.out_byte = afb_pkg::FRAME_ID;
                afb_pkg::IDX_ADDR_HI: step.res.out_byte = item.dest_address[15:8];
                afb_pkg::IDX_ADDR_LO: step.res.out_byte = item.dest_address[7:0];
                afb_pkg::IDX_OPTION:  step.res.out_byte = afb_pkg::OPTION_BYTE;
                afb_pkg::IDX_INSTR:   step.res.out_byte = item.instruction;
                afb_pkg::IDX_SLAVE:   step.res.out_byte = item.slave_address;
                default:              step.res.out_byte = check;
            endcase
            // abort flag rides on the start byte only
            step.res.error     = (idx == afb_pkg::IDX_START) && state.in_frame;
            step.res.frame_end = (idx == afb_pkg::IDX_CHECK);
            // checksum covers frame type onward
            if (idx == afb_pkg::IDX_TYPE) begin
                step.state_next.running_sum = step.res.out_byte;
            end else if (idx inside {[afb_pkg::IDX_ID:afb_pkg::IDX_SLAVE]}) begin
                step.state_next.running_sum = state.running_sum + step.res.out_byte;
            end
            step.last = (idx == afb_pkg::IDX_CHECK) ||
                        ((idx == afb_pkg::IDX_SLAVE) && (item.payload_length != 8'd0));
            if (step.last) begin
                step.state_next.in_frame        = (item.payload_length != 8'd0);
                step.state_next.bytes_remaining = item.payload_length;
            end
        end else if (!state.in_frame) begin
            // stray payload byte
            step.res.error = 1'b1;
            step.last      = 1'b1;
        end else if (idx == afb_pkg::IDX_START) begin
            step.res.out_byte                = item.data_byte;
            step.state_next.running_sum      = state.running_sum + item.data_byte;
            step.state_next.bytes_remaining  = rem_dec;
            step.last                        = (rem_dec != 8'd0);
        end else begin
            step.res.out_byte         = check;
            step.res.frame_end        = 1'b1;
            step.state_next.in_frame  = 1'b0;
            step.last                 = 1'b1;
        end
    end

endmodule

/* hw/rtl/afb_out_stage.sv */
// result register between the byte selector and the output channel
`timescale 1ns / 1ps

module afb_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  afb_pkg::out_item_t load_data,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output afb_pkg::out_item_t m_data
);

    logic               valid_reg;
    afb_pkg::out_item_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule

/* hw/rtl/api_tx16_frame_builder.sv */
// top level of the api transmit frame builder, 16-bit address request
// A start item (action 0) produces the ten header bytes 0x7E, length high, length
// low (payload_length + 7), frame type, frame id, address high, address low,
// option, instruction and slave address, one result item per cycle; a start with
// payload length 0 adds the checksum at once, for eleven items. Each payload item
// (action 1) gives its byte back, and the last one of the frame is followed by the
// checksum (0xFF minus the byte sum from frame type onward) with frame_end set.
// Error is raised on the start byte of a frame that cut an open one short, and on
// the single zero byte returned for a payload item outside any frame. Throughput
// is set by the output port, one result item per cycle: a payload item gives one
// result (two when it closes the frame), a start item ten or eleven. The input
// item register frees in the cycle of its last result, so the next item is taken
// then, and the result register keeps the two channels apart.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module api_tx16_frame_builder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  afb_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output afb_pkg::out_item_t m_data
);

    // held input item and its byte position
    logic                      item_valid_reg;
    afb_pkg::in_item_t         item_reg;
    logic [afb_pkg::IDX_W-1:0] idx_reg;
    logic [afb_pkg::IDX_W-1:0] idx_next;

    // frame state carried between items
    afb_pkg::frame_state_t     state_reg;

    afb_pkg::step_t            step;
    logic                      out_free;
    logic                      issue;

    afb_byte_sel u_byte_sel (
        .item  (item_reg),
        .idx   (idx_reg),
        .state (state_reg),
        .step  (step)
    );

    afb_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (issue),
        .load_data (step.res),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // one result per cycle whenever the result register can take it
    assign issue   = item_valid_reg && out_free;
    // the held item leaves with its last result, so a new one can enter then
    assign s_ready = !item_valid_reg || (issue && step.last);

    assign idx_next = step.last ? afb_pkg::IDX_START : idx_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= afb_pkg::IDX_START;
            state_reg      <= '0;
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            if (issue) begin
                idx_reg   <= idx_next;
                state_reg <= step.state_next;
            end
        end
    end

    // input item register, loaded on acceptance only
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    // byte position never runs past the checksum slot
    `AFB_ASSERT_HOLDS(a_idx_range, idx_reg <= afb_pkg::IDX_CHECK)
    // an issued checksum closes the frame
    `AFB_ASSERT_NEXT(a_end_closes, issue && step.res.frame_end, !state_reg.in_frame)
    // an open frame with nothing left is only the pending checksum of a payload item
    `AFB_ASSERT_HOLDS(a_open_empty,
        !(state_reg.in_frame && (state_reg.bytes_remaining == 8'd0)) ||
        (item_valid_reg && (idx_reg == afb_pkg::IDX_DATA_CHK)))

endmodule
